FILE: rtl/ipv_pkg.sv
// package: shared types and constants for the address text validator
package ipv_pkg;
  localparam int unsigned ChW = 8;
  localparam int unsigned FmtW = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned PrefDepth = 9;
  localparam int unsigned CntW = 6;

  localparam logic [CfgIdxW-1:0] CFG_V4_ONLY = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_V6_ONLY = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_REJ_PRIV = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_REJ_RSVD = 2'd3;

  localparam logic [FmtW-1:0] FMT_NONE = 2'd0;
  localparam logic [FmtW-1:0] FMT_V4 = 2'd1;
  localparam logic [FmtW-1:0] FMT_V6 = 2'd2;

  localparam logic [2:0] S_START = 3'd0;
  localparam logic [2:0] S_LEAD = 3'd1;
  localparam logic [2:0] S_GROUP = 3'd2;
  localparam logic [2:0] S_COLON = 3'd3;
  localparam logic [2:0] S_DCOLON = 3'd4;
  localparam logic [2:0] S_ERR = 3'd5;

  typedef struct packed {
    logic [ChW-1:0] ch;
    logic last_char;
  } in_beat_t;

  typedef struct packed {
    logic valid_res;
    logic [FmtW-1:0] format;
  } out_beat_t;

  function automatic logic [ChW-1:0] fold(input logic [ChW-1:0] c);
    fold = (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
  endfunction

  function automatic logic is_hex(input logic [ChW-1:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
  endfunction
endpackage

FILE: rtl/ipv_stream_if.sv
// interface: valid/ready channel with a payload
interface ipv_stream_if #(parameter type payload_t = logic) ();
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/ip_address_text_validator_top.sv
// top level: address text validator, one char beat per cycle unless stalled
// a last beat's result is registered in the output or skid register
// throughput: one character beat per cycle while the skid stage is empty
// reset: rst_ni clears config, parser state and the output valid
// the prefix store holds no reset, it is read only where already written
module ip_address_text_validator_top (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [ipv_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic cfg_data_i,
  ipv_stream_if.sink in_if,
  ipv_stream_if.source out_if
);
  import ipv_pkg::*;

  logic v4o_q, v6o_q, rpriv_q, rrsvd_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [ChW-1:0] pre_q [PrefDepth];
  logic [8:0] gval_q, gval_d;
  logic [1:0] gdig_q, gdig_d;
  logic [2:0] gidx_q, gidx_d;
  logic [15:0] oct_q, oct_d;
  logic [3:0] blk_q, blk_d;
  logic [2:0] hex_q, hex_d;
  logic fcol_q, fcol_d, fdot_q, fdot_d, fv4e_q, fv4e_d, fcomp_q, fcomp_d;
  logic fdc_q, fdc_d, fpok_q, fpok_d;
  logic [2:0] pos_q, pos_d, org_q, org_d;
  logic ov_q, sk_q;
  out_beat_t o_q, s_q, res;
  logic acc, push;
  logic [ChW-1:0] c;
  logic hx, dig, col, dot, last;
  logic [ChW-1:0] raw [PrefDepth];
  logic [ChW-1:0] p [PrefDepth];
  logic [11:0] gv10;
  logic v4ok, v6ok, rok4, rok6, ok;
  logic [7:0] oa, ob;
  logic fc_s, fe_s, p5f, p3ff3, p2001, pdb8;
  logic [FmtW-1:0] fmt;

  assign c = in_if.data.ch;
  assign last = in_if.data.last_char;
  assign in_if.ready = !sk_q;
  assign acc = in_if.valid && in_if.ready;
  assign push = acc && last;
  assign hx = is_hex(c);
  assign dig = c >= 8'h30 && c <= 8'h39;
  assign col = c == 8'h3a;
  assign dot = c == 8'h2e;
  assign gv10 = {3'd0, gval_q} * 12'd10 + {8'd0, c[3:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {v4o_q, v6o_q, rpriv_q, rrsvd_q} <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_V4_ONLY: v4o_q <= cfg_data_i;
        CFG_V6_ONLY: v6o_q <= cfg_data_i;
        CFG_REJ_PRIV: rpriv_q <= cfg_data_i;
        CFG_REJ_RSVD: rrsvd_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < PrefDepth; i++)
      if (acc && cnt_q == CntW'(i)) pre_q[i] <= c;
  end

  always_comb begin
    cnt_d = (cnt_q < CntW'(63)) ? cnt_q + 1'b1 : cnt_q;
    gval_d = gval_q; gdig_d = gdig_q; gidx_d = gidx_q; oct_d = oct_q;
    blk_d = blk_q; hex_d = hex_q; pos_d = pos_q; org_d = org_q;
    fcol_d = fcol_q | col; fdc_d = fdc_q | (col & fdot_q);
    fdot_d = fdot_q | dot; fv4e_d = fv4e_q; fcomp_d = fcomp_q; fpok_d = fpok_q;
    if (!fdot_q) begin
      if (dot) begin
        if (pos_q == S_GROUP) begin
          if (org_q == S_DCOLON) fpok_d = blk_q <= 4'd6;
          else if (org_q == S_COLON)
            fpok_d = (fcomp_q && blk_q <= 4'd6) || blk_q == 4'd6;
        end
      end else begin
        case (pos_q)
          S_START: begin
            if (hx) begin pos_d = S_GROUP; org_d = S_START; hex_d = 3'd1; end
            else if (col) pos_d = S_LEAD;
            else pos_d = S_ERR;
          end
          S_LEAD: begin
            if (col) begin
              fcomp_d = 1'b1; pos_d = S_DCOLON;
              if (blk_q < 4'd15) blk_d = blk_q + 1'b1;
            end else pos_d = S_ERR;
          end
          S_GROUP: begin
            if (hx) begin
              hex_d = hex_q + 1'b1;
              if (hex_q >= 3'd4) pos_d = S_ERR;
            end else if (col) begin
              pos_d = S_COLON;
              if (blk_q < 4'd15) blk_d = blk_q + 1'b1;
            end else pos_d = S_ERR;
          end
          S_COLON: begin
            if (col) begin
              if (fcomp_q) pos_d = S_ERR;
              else begin
                fcomp_d = 1'b1; pos_d = S_DCOLON;
                if (blk_q < 4'd15) blk_d = blk_q + 1'b1;
              end
            end else if (hx) begin pos_d = S_GROUP; org_d = S_COLON; hex_d = 3'd1; end
            else pos_d = S_ERR;
          end
          S_DCOLON: begin
            if (hx) begin pos_d = S_GROUP; org_d = S_DCOLON; hex_d = 3'd1; end
            else pos_d = S_ERR;
          end
          default: pos_d = S_ERR;
        endcase
      end
    end
    if (col) begin
      gval_d = '0; gdig_d = '0; gidx_d = '0; fv4e_d = 1'b0;
    end else if (!fv4e_q) begin
      if (dig) begin
        if ((gdig_q >= 2'd1 && gval_q == '0) || gdig_q >= 2'd3) fv4e_d = 1'b1;
        else if (gv10 > 12'd255) begin fv4e_d = 1'b1; gval_d = gv10[8:0]; end
        else begin gval_d = gv10[8:0]; gdig_d = gdig_q + 1'b1; end
      end else if (dot) begin
        if (gdig_q == '0 || gidx_q >= 3'd3) fv4e_d = 1'b1;
        else begin
          if (gidx_q == 3'd0) oct_d[15:8] = gval_q[7:0];
          else if (gidx_q == 3'd1) oct_d[7:0] = gval_q[7:0];
          gidx_d = gidx_q + 1'b1; gdig_d = '0; gval_d = '0;
        end
      end else fv4e_d = 1'b1;
    end
  end

  always_comb begin
    for (int i = 0; i < PrefDepth; i++) begin
      raw[i] = (cnt_q == CntW'(i)) ? c : pre_q[i];
      p[i] = fold(raw[i]);
    end
    fmt = fcol_d ? FMT_V6 : (fdot_d ? FMT_V4 : FMT_NONE);
    v4ok = !fv4e_d && gidx_d == 3'd3 && gdig_d >= 2'd1;
    if (fdot_d) v6ok = fpok_d && !fdc_d && v4ok;
    else if (pos_d == S_GROUP)
      v6ok = (fcomp_d && blk_d <= 4'd7) || blk_d == 4'd7;
    else if (pos_d == S_DCOLON) v6ok = blk_d <= 4'd8;
    else v6ok = 1'b0;
    oa = oct_d[15:8]; ob = oct_d[7:0];
    rok4 = !(rpriv_q && (oa == 8'd10 || (oa == 8'd172 && ob >= 8'd16 && ob <= 8'd31) ||
                         (oa == 8'd192 && ob == 8'd168))) &&
           !(rrsvd_q && (oa == 8'd0 || oa >= 8'd240 || oa == 8'd127 ||
                         (oa == 8'd169 && ob == 8'd254)));
    fc_s = p[0] == 8'h66 && (p[1] == 8'h63 || p[1] == 8'h64);
    fe_s = p[0] == 8'h66 && p[1] == 8'h65 && (p[2] == 8'h38 || p[2] == 8'h39 ||
           p[2] == 8'h61 || p[2] == 8'h62);
    p5f = p[0] == 8'h35 && p[1] == 8'h66;
    p3ff3 = p[0] == 8'h33 && p[1] == 8'h66 && p[2] == 8'h66 && p[3] == 8'h33;
    p2001 = p[0] == 8'h32 && p[1] == 8'h30 && p[2] == 8'h30 && p[3] == 8'h31 &&
            p[4] == 8'h3a && p[5] == 8'h30;
    pdb8 = p2001 && p[6] == 8'h64 && p[7] == 8'h62 && p[8] == 8'h38;
    rok6 = 1'b1;
    if (rpriv_q && cnt_d >= CntW'(2) && fc_s) rok6 = 1'b0;
    else if (rrsvd_q) begin
      // short forms match the exact text, case kept
      if (cnt_d == CntW'(2)) rok6 = !(raw[0] == 8'h3a && raw[1] == 8'h3a);
      else if (cnt_d == CntW'(3))
        rok6 = !((raw[0] == 8'h3a && raw[1] == 8'h3a && raw[2] == 8'h31) ||
                 (raw[0] == 8'h35 && raw[1] == 8'h66 && raw[2] == 8'h3a));
      else if (cnt_d >= CntW'(4))
        rok6 = !((cnt_d >= CntW'(5) && fe_s) || (cnt_d >= CntW'(9) && pdb8) || p5f ||
                 p3ff3 || (cnt_d >= CntW'(8) && p2001 && p[6] == 8'h30 && p[7] == 8'h31));
    end
    ok = fmt != FMT_NONE;
    if (ok && !(v4o_q && v6o_q)) begin
      if (v4o_q && fmt == FMT_V6) ok = 1'b0;
      else if (v6o_q && fmt == FMT_V4) ok = 1'b0;
    end
    if (ok && fmt == FMT_V4) ok = v4ok && rok4;
    else if (ok && fmt == FMT_V6) ok = v6ok && rok6;
    res.valid_res = ok;
    res.format = fmt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; gval_q <= '0; gdig_q <= '0; gidx_q <= '0; oct_q <= '0;
      blk_q <= '0; hex_q <= '0; pos_q <= S_START; org_q <= S_START;
      {fcol_q, fdot_q, fv4e_q, fcomp_q, fdc_q, fpok_q} <= '0;
    end else if (acc) begin
      if (last) begin
        cnt_q <= '0; gval_q <= '0; gdig_q <= '0; gidx_q <= '0; oct_q <= '0;
        blk_q <= '0; hex_q <= '0; pos_q <= S_START; org_q <= S_START;
        {fcol_q, fdot_q, fv4e_q, fcomp_q, fdc_q, fpok_q} <= '0;
      end else begin
        cnt_q <= cnt_d; gval_q <= gval_d; gdig_q <= gdig_d; gidx_q <= gidx_d;
        oct_q <= oct_d; blk_q <= blk_d; hex_q <= hex_d; pos_q <= pos_d; org_q <= org_d;
        fcol_q <= fcol_d; fdot_q <= fdot_d; fv4e_q <= fv4e_d; fcomp_q <= fcomp_d;
        fdc_q <= fdc_d; fpok_q <= fpok_d;
      end
    end
  end

  // output register plus skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0; sk_q <= 1'b0;
    end else begin
      if (!ov_q || out_if.ready) begin
        ov_q <= sk_q || push;
        sk_q <= 1'b0;
      end else if (push) begin
        sk_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!ov_q || out_if.ready) o_q <= sk_q ? s_q : res;
    else if (push) s_q <= res;
  end

  assign out_if.valid = ov_q;
  assign out_if.data = o_q;
endmodule

FILE: rtl/ipv_checker.sv
// checker: port level assertions for the validator, bound to the top level
module ipv_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic [1:0] out_format_i,
  input logic out_res_i
);
  import ipv_pkg::*;

  a_fmt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_format_i != 2'd3) else $error("bad format");
  a_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_format_i == FMT_NONE |-> !out_res_i) else $error("pass without sep");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i) else $error("beat dropped");
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i) else $error("stall with empty output");
  a_rdy2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i) else $error("not ready without pending beat");
endmodule

bind ip_address_text_validator_top ipv_checker u_ipv_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_if.valid), .in_ready_i(in_if.ready),
  .out_valid_i(out_if.valid), .out_ready_i(out_if.ready),
  .out_format_i(out_if.data.format), .out_res_i(out_if.data.valid_res)
);

FILE: tb/tb_top.sv
// testbench: address text validator checked beat by beat against a behavioral predictor
`timescale 1ns / 100ps
module tb_top;
  import ipv_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = CFG_V4_ONLY;
  logic cfg_data_i = 1'b0;

  ipv_stream_if #(.payload_t(in_beat_t)) in_if ();
  ipv_stream_if #(.payload_t(out_beat_t)) out_if ();

  ip_address_text_validator_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_if(in_if), .out_if(out_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #4000000;
    $display("tb_top failed");
    $finish;
  end

  // predictor state
  logic m_v4only, m_v6only, m_rpriv, m_rrsvd;
  int unsigned p_len;
  logic [7:0] p_text [9];
  int unsigned g_val, g_dig, g_idx, oct_a, oct_b, blk, hexd;
  logic f_colon, f_dot, f_v4err, f_comp, f_dotcolon, f_prefok;
  logic [2:0] v6_state, v6_from;

  out_beat_t verdicts_q [$];
  int mismatches = 0;
  logic rx_hold = 1'b0;
  logic rx_noidle = 1'b0;
  logic tx_noidle = 1'b0;

  function automatic logic hexc(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [7:0] lc(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic logic text_starts(string s);
    for (int i = 0; i < s.len() && i < 9; i++)
      if (lc(p_text[i]) != s[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic text_is(string s);
    for (int i = 0; i < s.len() && i < 9; i++)
      if (p_text[i] != s[i]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic clear_text_state();
    p_len = 0;
    foreach (p_text[i]) p_text[i] = 8'h00;
    g_val = 0; g_dig = 0; g_idx = 0; oct_a = 0; oct_b = 0; blk = 0; hexd = 0;
    {f_colon, f_dot, f_v4err, f_comp, f_dotcolon, f_prefok} = '0;
    v6_state = S_START;
    v6_from = S_START;
  endtask

  task automatic add_block();
    if (blk < 15) blk++;
  endtask

  task automatic v6_step(logic [7:0] c);
    logic hx;
    hx = hexc(c);
    case (v6_state)
      S_START: begin
        if (hx) begin v6_state = S_GROUP; v6_from = S_START; hexd = 1; end
        else if (c == ":") v6_state = S_LEAD;
        else v6_state = S_ERR;
      end
      S_LEAD: begin
        if (c == ":") begin f_comp = 1; add_block(); v6_state = S_DCOLON; end
        else v6_state = S_ERR;
      end
      S_GROUP: begin
        if (hx) begin
          hexd++;
          if (hexd > 4) v6_state = S_ERR;
        end else if (c == ":") begin
          add_block(); v6_state = S_COLON;
        end else v6_state = S_ERR;
      end
      S_COLON: begin
        if (c == ":") begin
          if (f_comp) v6_state = S_ERR;
          else begin f_comp = 1; add_block(); v6_state = S_DCOLON; end
        end else if (hx) begin v6_state = S_GROUP; v6_from = S_COLON; hexd = 1; end
        else v6_state = S_ERR;
      end
      S_DCOLON: begin
        if (hx) begin v6_state = S_GROUP; v6_from = S_DCOLON; hexd = 1; end
        else v6_state = S_ERR;
      end
      default: v6_state = S_ERR;
    endcase
  endtask

  task automatic v4_step(logic [7:0] c);
    if (c == ":") begin
      g_val = 0; g_dig = 0; g_idx = 0; f_v4err = 0;
    end else if (!f_v4err) begin
      if (c >= "0" && c <= "9") begin
        if ((g_dig >= 1 && g_val == 0) || g_dig >= 3) f_v4err = 1;
        else begin
          g_val = g_val * 10 + (c - "0");
          if (g_val > 255) f_v4err = 1;
          else g_dig++;
        end
      end else if (c == ".") begin
        if (g_dig == 0 || g_idx >= 3) f_v4err = 1;
        else begin
          if (g_idx == 0) oct_a = g_val;
          else if (g_idx == 1) oct_b = g_val;
          g_idx++; g_dig = 0; g_val = 0;
        end
      end else f_v4err = 1;
    end
  endtask

  function automatic logic v4_good();
    return !f_v4err && g_idx == 3 && g_dig >= 1;
  endfunction

  function automatic logic v6_good();
    if (f_dot) return f_prefok && !f_dotcolon && v4_good();
    if (v6_state == S_GROUP) return (f_comp && blk + 1 <= 8) || blk + 1 == 8;
    if (v6_state == S_DCOLON) return blk <= 8;
    return 1'b0;
  endfunction

  function automatic logic v6_range_good();
    logic [7:0] t;
    if (m_rpriv && p_len >= 2 && (text_starts("fc") || text_starts("fd"))) return 1'b0;
    if (!m_rrsvd) return 1'b1;
    if (p_len == 2) return !text_is("::");
    if (p_len == 3) return !(text_is("::1") || text_is("5f:"));
    if (p_len >= 4) begin
      if (p_len >= 5 && text_starts("fe")) begin
        t = lc(p_text[2]);
        if (t == "8" || t == "9" || t == "a" || t == "b") return 1'b0;
      end
      if ((p_len >= 9 && text_starts("2001:0db8")) || text_starts("5f") ||
          text_starts("3ff3") || (p_len >= 8 && text_starts("2001:001")))
        return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic v4_range_good();
    if (m_rpriv && (oct_a == 10 || (oct_a == 172 && oct_b >= 16 && oct_b <= 31) ||
        (oct_a == 192 && oct_b == 168))) return 1'b0;
    if (m_rrsvd && (oct_a == 0 || oct_a >= 240 || oct_a == 127 ||
        (oct_a == 169 && oct_b == 254))) return 1'b0;
    return 1'b1;
  endfunction

  task automatic predict_char(in_beat_t b);
    logic [7:0] c;
    out_beat_t r;
    logic ok;
    c = b.ch;
    if (p_len < 9) p_text[p_len] = c;
    if (p_len < 63) p_len++;
    if (c == ":") begin
      f_colon = 1;
      if (f_dot) f_dotcolon = 1;
    end
    if (!f_dot) begin
      if (c == ".") begin
        if (v6_state == S_GROUP) begin
          if (v6_from == S_DCOLON) f_prefok = blk <= 6;
          else if (v6_from == S_COLON) f_prefok = (f_comp && blk <= 6) || blk == 6;
        end
      end else v6_step(c);
    end
    if (c == ".") f_dot = 1;
    v4_step(c);
    if (b.last_char) begin
      r.format = f_colon ? FMT_V6 : (f_dot ? FMT_V4 : FMT_NONE);
      ok = r.format != FMT_NONE;
      if (ok && !(m_v4only && m_v6only)) begin
        if (m_v4only && r.format == FMT_V6) ok = 0;
        else if (m_v6only && r.format == FMT_V4) ok = 0;
      end
      if (ok && r.format == FMT_V4) ok = v4_good() && v4_range_good();
      else if (ok && r.format == FMT_V6) ok = v6_good() && v6_range_good();
      r.valid_res = ok;
      verdicts_q.push_back(r);
      clear_text_state();
    end
  endtask

  // output side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= !rx_hold && (rx_noidle || $urandom_range(0, 99) >= 15);
    end
  end

  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (verdicts_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", out_if.data);
      end else begin
        want = verdicts_q.pop_front();
        if (want.valid_res !== out_if.data.valid_res || want.format !== out_if.data.format) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected valid_res %b format %0d, got %b %0d",
                     want.valid_res, want.format, out_if.data.valid_res, out_if.data.format);
        end
      end
    end
  end

  task automatic send_char(logic [7:0] c, logic l);
    while (!tx_noidle && $urandom_range(0, 99) < 15) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= '{ch: c, last_char: l};
    do @(posedge clk_i); while (!in_if.ready);
    predict_char('{ch: c, last_char: l});
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (verdicts_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_reg(logic [CfgIdxW-1:0] idx, logic v);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= v;
    @(posedge clk_i);
    case (idx)
      CFG_V4_ONLY: m_v4only = v;
      CFG_V6_ONLY: m_v6only = v;
      CFG_REJ_PRIV: m_rpriv = v;
      default: m_rrsvd = v;
    endcase
  endtask

  task automatic set_mode(logic [3:0] m);
    set_reg(CFG_V4_ONLY, m[0]);
    set_reg(CFG_V6_ONLY, m[1]);
    set_reg(CFG_REJ_PRIV, m[2]);
    set_reg(CFG_REJ_RSVD, m[3]);
    cfg_we_i <= 1'b0;
  endtask

  function automatic string hex_group();
    string s, h;
    int n;
    h = "0123456789abcdefABCDEF";
    s = "";
    n = $urandom_range(1, 5);
    for (int i = 0; i < n; i++) s = {s, string'(h[$urandom_range(0, 21)])};
    return s;
  endfunction

  function automatic string dec_group();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return $sformatf("%0d", $urandom_range(0, 300));
    if (k == 1) return $sformatf("0%0d", $urandom_range(0, 9));
    if (k < 4) return $sformatf("%0d", $urandom_range(0, 9));
    return $sformatf("%0d", $urandom_range(0, 255));
  endfunction

  function automatic string v4_text();
    int n;
    string s;
    int k;
    k = $urandom_range(0, 7);
    n = (k == 0) ? $urandom_range(1, 6) : 4;
    s = dec_group();
    if (k == 1) s = string'(8'(10 + 0));
    if (k == 1) s = "10";
    if (k == 2) s = "172";
    if (k == 3) s = "192";
    if (k == 4) s = "169";
    for (int i = 1; i < n; i++) begin
      if (i == 1 && k == 2) s = {s, ".", $sformatf("%0d", $urandom_range(14, 33))};
      else if (i == 1 && k == 3) s = {s, ".168"};
      else if (i == 1 && k == 4) s = {s, ".254"};
      else s = {s, ".", dec_group()};
    end
    return s;
  endfunction

  function automatic string v6_text();
    string s;
    int n, gap;
    string heads [8];
    heads = '{"fc", "fd", "fe8", "5f", "3ff3", "2001:001", "2001:0db8", "FE9"};
    n = $urandom_range(1, 9);
    gap = $urandom_range(0, 2) == 0 ? -1 : $urandom_range(0, n);
    s = ($urandom_range(0, 4) == 0) ? heads[$urandom_range(0, 7)] : hex_group();
    for (int i = 1; i < n; i++) begin
      if (i == gap) s = {s, "::", hex_group()};
      else s = {s, ":", hex_group()};
    end
    if (gap == n) s = {s, "::"};
    if ($urandom_range(0, 3) == 0) begin
      s = {s, ":", $sformatf("%0d.%0d.%0d.%0d", $urandom_range(0, 255),
           $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255))};
    end
    if ($urandom_range(0, 9) == 0) s = {"::", s};
    return s;
  endfunction

  initial begin
    string dir_tab [22];
    logic [1:0] dir_fmt [22];
    int chars;
    string s;
    dir_tab = '{"1.2.3.4", "255.255.255.255", "0.0.0.0", "256.1.1.1", "01.1.1.1",
                "1.2.3", "1.2.3.4.5", "::", "::1", "1::", "1:2:3:4:5:6:7:8",
                "1:2:3:4:5:6:7:8:9", "1::2::3", "::ffff:1.2.3.4", "abcd", "12345",
                "ABCD:ef01::", "1.2.3.4:5", "1.2.3.x", "fe80::1", "5f:", "12345::"};
    dir_fmt = '{FMT_V4, FMT_V4, FMT_V4, FMT_V4, FMT_V4, FMT_V4, FMT_V4, FMT_V6, FMT_V6,
                FMT_V6, FMT_V6, FMT_V6, FMT_V6, FMT_V6, FMT_NONE, FMT_NONE, FMT_V6,
                FMT_V6, FMT_V4, FMT_V6, FMT_V6, FMT_V6};
    in_if.valid = 1'b0;
    in_if.data = '0;
    m_v4only = 0; m_v6only = 0; m_rpriv = 0; m_rrsvd = 0;
    clear_text_state();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < 22; i++) begin
      send_text(dir_tab[i]);
      if (verdicts_q[$].format !== dir_fmt[i]) begin
        mismatches++;
        if (mismatches <= 10) $display("format table row %0d wrong", i);
      end
    end
    send_char(8'h00, 1'b0); send_char(8'hff, 1'b0); send_char(8'h80, 1'b1);
    drain();

    chars = 0;
    for (int ph = 0; ph < 16; ph++) begin
      set_mode(ph[3:0]);
      tx_noidle = (ph == 5);
      rx_noidle = (ph == 5);
      while (chars < (ph + 1) * 95) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: s = v4_text();
          4, 5, 6, 7: s = v6_text();
          default: begin
            s = "";
            for (int k = $urandom_range(1, 12); k > 0; k--)
              s = {s, string'(8'($urandom_range(0, 255)))};
          end
        endcase
        if (s.len() == 0) s = "x";
        if ($urandom_range(0, 30) == 0)
          for (int k = 0; k < 60; k++) s = {s, "1"};
        for (int k = 0; k < s.len(); k++) begin
          send_char(s[k], k == s.len() - 1);
          chars++;
        end
      end
      drain();
    end
    tx_noidle = 0; rx_noidle = 0;
    set_mode(4'b1111);
    rx_hold = 1'b1;
    fork
      begin
        repeat (200) @(posedge clk_i);
        rx_hold = 1'b0;
      end
      for (int k = 0; k < 30; k++) send_text("::");
    join
    drain();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && verdicts_q.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule

FILE: ip_address_text_validator_top.f
rtl/ipv_pkg.sv
rtl/ipv_stream_if.sv
rtl/ip_address_text_validator_top.sv
rtl/ipv_checker.sv
tb/tb_top.sv
